// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/hbm_pkg.sv -----
package hbm_pkg;

   // Result kinds
   localparam logic [2:0] KIND_IGNORED   = 3'd0;
   localparam logic [2:0] KIND_CHANGED   = 3'd1;
   localparam logic [2:0] KIND_SAME      = 3'd2;
   localparam logic [2:0] KIND_EMERGENCY = 3'd3;
   localparam logic [2:0] KIND_QUERY     = 3'd4;

   // Input actions
   localparam logic ACTION_FRAME = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Register indexes and reset values
   localparam logic CSR_HEARTBEAT_BASE = 1'b0;
   localparam logic CSR_EMERGENCY_BASE = 1'b1;
   localparam logic [10:0] HEARTBEAT_BASE_RESET = 11'd1792;
   localparam logic [10:0] EMERGENCY_BASE_RESET = 11'd128;

   localparam int NODE_COUNT_DEFAULT = 128;

   // Decoded request, passed from the decoder to the controller
   typedef struct packed {
      logic       is_query;
      logic       is_heartbeat;
      logic       is_emergency;
      logic       in_range;
      logic [6:0] node;
   } hbm_decode_type;

   // One result transaction
   typedef struct packed {
      logic [2:0]  kind;
      logic [6:0]  node;
      logic        state_known;
      logic [6:0]  nmt_state;
      logic [31:0] boot_count;
      logic [15:0] error_code;
      logic [7:0]  error_register;
      logic [39:0] vendor_bytes;
   } hbm_rsp_type;

endpackage

// ----- design/hbm_req_if.sv -----
interface hbm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [10:0] can_id;
   logic [3:0]  frame_len;
   logic [63:0] payload;
   logic [6:0]  query_node;

   modport source (output valid, action, can_id, frame_len, payload, query_node,
                   input ready);
   modport sink   (input valid, action, can_id, frame_len, payload, query_node,
                   output ready);
endinterface

// ----- design/hbm_rsp_if.sv -----
interface hbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [6:0]  node;
   logic        state_known;
   logic [6:0]  nmt_state;
   logic [31:0] boot_count;
   logic [15:0] error_code;
   logic [7:0]  error_register;
   logic [39:0] vendor_bytes;

   modport source (output valid, kind, node, state_known, nmt_state, boot_count,
                   error_code, error_register, vendor_bytes,
                   input ready);
   modport sink   (input valid, kind, node, state_known, nmt_state, boot_count,
                   error_code, error_register, vendor_bytes,
                   output ready);
endinterface

// ----- design/hbm_decode.sv -----
module hbm_decode #(
   parameter int NODE_COUNT = hbm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic                  action,
   input  logic [10:0]           can_id,
   input  logic [3:0]            frame_len,
   input  logic [6:0]            query_node,
   input  logic [10:0]           heartbeat_base,
   input  logic [10:0]           emergency_base,
   output hbm_pkg::hbm_decode_type dec
);
   import hbm_pkg::*;

   logic [11:0] hb_diff;
   logic [11:0] em_diff;
   logic        hb_match;
   logic        em_match;
   logic [6:0]  node_sel;

   // Offset of the identifier into each window; a borrow means below the base
   assign hb_diff = {1'b0, can_id} - {1'b0, heartbeat_base};
   assign em_diff = {1'b0, can_id} - {1'b0, emergency_base};

   assign hb_match = !hb_diff[11] && (hb_diff[10:7] == 4'd0) && (frame_len != 4'd0);
   // Emergency base itself is excluded, and frames need all eight bytes
   assign em_match = !em_diff[11] && (em_diff[10:7] == 4'd0) &&
                     (em_diff[6:0] != 7'd0) && frame_len[3];

   // Pick the node the transaction concerns; heartbeat wins over emergency
   always_comb begin
      if (action == ACTION_QUERY) begin
         node_sel = query_node;
      end else if (hb_match) begin
         node_sel = hb_diff[6:0];
      end else begin
         node_sel = em_diff[6:0];
      end
   end

   assign dec.is_query     = (action == ACTION_QUERY);
   assign dec.is_heartbeat = (action == ACTION_FRAME) && hb_match;
   assign dec.is_emergency = (action == ACTION_FRAME) && !hb_match && em_match;
   assign dec.in_range     = ({25'd0, node_sel} < NODE_COUNT);
   assign dec.node         = node_sel;

endmodule

// ----- design/hbm_table.sv -----
module hbm_table #(
   parameter int NODE_COUNT = hbm_pkg::NODE_COUNT_DEFAULT,
   parameter int ADDR_W     = $clog2(NODE_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [6:0]        wr_state,
   input  logic [31:0]       wr_boot,
   output logic              rd_known,
   output logic [6:0]        rd_state,
   output logic [31:0]       rd_boot
);
   import hbm_pkg::*;

   logic [38:0]           mem [NODE_COUNT];
   logic [38:0]           rd_word_ff;
   logic                  rd_known_ff;
   logic [NODE_COUNT-1:0] valid_ff;

   // Synchronous memory: state in the top bits, boot counter below
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= {wr_state, wr_boot};
      end
   end

   // Known flags; an entry never written reads as zero boot count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_known_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_known_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_known = rd_known_ff;
   assign rd_state = rd_known_ff ? rd_word_ff[38:32] : 7'd0;
   assign rd_boot  = rd_known_ff ? rd_word_ff[31:0]  : 32'd0;

endmodule

// ----- design/canopen_heartbeat_monitor_top.sv -----
// CANopen heartbeat consumer and emergency decoder.
// req_if carries one transaction per received CAN frame or per node status
// query; rsp_if returns exactly one result transaction for each of them.
// Heartbeat frames update the node's stored NMT state and boot counter,
// emergency frames are unpacked, other frames give an all-zero result.
// Each request reads the node table at its accept edge (a synchronous
// memory with separate read and write ports); a heartbeat's updated entry
// is written back at the edge that loads the result register. A new request
// is accepted only after the previous one has loaded the result register.
// rsp_if.valid rises at the edge after the accept edge when the result
// register is free.
// If rsp_if.ready stays low, the result register holds; one further request
// may be accepted and then waits with its table data until the register frees.
// Synchronous reset clears the known flags of all nodes at once (so boot
// counts read as zero), restores both window bases and empties the result
// register. Write csr_* only while no request is in flight.
module canopen_heartbeat_monitor_top #(
   parameter int NODE_COUNT = hbm_pkg::NODE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   hbm_req_if.sink     req_if,
   hbm_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);
   import hbm_pkg::*;

   localparam int ADDR_W = $clog2(NODE_COUNT);
   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic           state_ff, state_in;
   logic [10:0]    hb_base_ff;
   logic [10:0]    em_base_ff;
   hbm_decode_type dec;
   hbm_decode_type dec_ff;
   logic [63:0]    payload_ff;
   hbm_rsp_type    rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           fire;
   logic           tbl_known;
   logic [6:0]     tbl_state;
   logic [31:0]    tbl_boot;
   logic [31:0]    boot_next;
   logic [6:0]     hb_state;
   logic           wr_en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_base_ff <= HEARTBEAT_BASE_RESET;
         em_base_ff <= EMERGENCY_BASE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HEARTBEAT_BASE: hb_base_ff <= csr_wdata;
            CSR_EMERGENCY_BASE: em_base_ff <= csr_wdata;
            default:            hb_base_ff <= hb_base_ff;
         endcase
      end
   end

   hbm_decode #(
      .NODE_COUNT (NODE_COUNT)
   ) u_decode (
      .action         (req_if.action),
      .can_id         (req_if.can_id),
      .frame_len      (req_if.frame_len),
      .query_node     (req_if.query_node),
      .heartbeat_base (hb_base_ff),
      .emergency_base (em_base_ff),
      .dec            (dec)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign fire         = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_if.ready);

   // Hold the decoded transaction while the table read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         dec_ff     <= dec;
         payload_ff <= req_if.payload;
      end
   end

   hbm_table #(
      .NODE_COUNT (NODE_COUNT),
      .ADDR_W     (ADDR_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (dec.node[ADDR_W-1:0]),
      .wr_en    (wr_en),
      .wr_addr  (dec_ff.node[ADDR_W-1:0]),
      .wr_state (hb_state),
      .wr_boot  (boot_next),
      .rd_known (tbl_known),
      .rd_state (tbl_state),
      .rd_boot  (tbl_boot)
   );

   // Heartbeat update: byte 0 of zero is a boot-up
   assign hb_state  = payload_ff[6:0];
   assign boot_next = tbl_boot + {31'd0, (payload_ff[7:0] == 8'd0)};
   assign wr_en     = fire && dec_ff.is_heartbeat && dec_ff.in_range;

   // Build the result transaction
   always_comb begin
      rsp_in = '0;
      if (dec_ff.is_query) begin
         rsp_in.kind = KIND_QUERY;
         rsp_in.node = dec_ff.node;
         if (dec_ff.in_range) begin
            rsp_in.state_known = tbl_known;
            rsp_in.nmt_state   = tbl_state;
            rsp_in.boot_count  = tbl_boot;
         end
      end else if (dec_ff.is_heartbeat && dec_ff.in_range) begin
         rsp_in.kind        = (!tbl_known || (tbl_state != hb_state)) ?
                              KIND_CHANGED : KIND_SAME;
         rsp_in.node        = dec_ff.node;
         rsp_in.state_known = 1'b1;
         rsp_in.nmt_state   = hb_state;
         rsp_in.boot_count  = boot_next;
      end else if (dec_ff.is_emergency && dec_ff.in_range) begin
         rsp_in.kind           = KIND_EMERGENCY;
         rsp_in.node           = dec_ff.node;
         rsp_in.error_code     = payload_ff[15:0];
         rsp_in.error_register = payload_ff[23:16];
         rsp_in.vendor_bytes   = payload_ff[63:24];
      end
   end

   // Sequencer and result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_ff.kind;
   assign rsp_if.node           = rsp_ff.node;
   assign rsp_if.state_known    = rsp_ff.state_known;
   assign rsp_if.nmt_state      = rsp_ff.nmt_state;
   assign rsp_if.boot_count     = rsp_ff.boot_count;
   assign rsp_if.error_code     = rsp_ff.error_code;
   assign rsp_if.error_register = rsp_ff.error_register;
   assign rsp_if.vendor_bytes   = rsp_ff.vendor_bytes;

endmodule

// ----- design/hbm_checker.sv -----
`include "assert_macros.svh"

module hbm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  kind,
   input logic [6:0]  node,
   input logic [31:0] boot_count
);
   import hbm_pkg::*;

   // Stalled result holds its kind
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(kind))

   // One request in flight: ready drops after each accepted transaction
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // Reset empties the result register
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Ignored frames carry no node and no count
   `ASSERT_IMPLY(a_ignored_zero, clock, reset, rsp_valid && (kind == KIND_IGNORED),
                 (node == 7'd0) && (boot_count == 32'd0))

endmodule

bind canopen_heartbeat_monitor_top hbm_checker u_hbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .kind       (rsp_if.kind),
   .node       (rsp_if.node),
   .boot_count (rsp_if.boot_count)
);
